// ----- rtl/core/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
package uer_pkg;

   localparam int SAMPLES_DEF = 5;

   localparam int CNT_W   = 16;
   localparam int SUM_W   = 19;
   localparam int SCALE_W = 12;
   localparam int OFS_W   = 16;
   localparam int PROD_W  = SUM_W + SCALE_W;
   localparam int P_W     = PROD_W - 8;
   localparam int DIST_W  = 21;
   localparam int DIFF_W  = P_W + 2;
   localparam int CSR_W   = 16;
   localparam int IDX_W   = 3;

   localparam logic signed [DIFF_W-1:0] DIST_MAX = DIFF_W'(1048575);

   localparam logic [IDX_W-1:0] CSR_ENABLE     = 3'd0;
   localparam logic [IDX_W-1:0] CSR_TRIG_TICKS = 3'd1;
   localparam logic [IDX_W-1:0] CSR_PERIOD     = 3'd2;
   localparam logic [IDX_W-1:0] CSR_SCALE      = 3'd3;
   localparam logic [IDX_W-1:0] CSR_OFFSET     = 3'd4;

   localparam logic [CNT_W-1:0]   TRIG_TICKS_RST = 16'd30;
   localparam logic [CNT_W-1:0]   PERIOD_RST     = 16'd50000;
   localparam logic [SCALE_W-1:0] SCALE_RST      = 12'd374;
   localparam logic [OFS_W-1:0]   OFFSET_RST     = 16'd10240;

   typedef struct packed {
      logic               enable;
      logic [CNT_W-1:0]   trig_ticks;
      logic [CNT_W-1:0]   period;
      logic [SCALE_W-1:0] scale;
      logic [OFS_W-1:0]   offset;
   } cfg_type;

   typedef struct packed {
      logic             trig;
      logic             valid_res;
      logic [SUM_W-1:0] sum;
   } tick_type;

endpackage

// ----- rtl/core/uer_fsm.sv -----
// Ranging sequencer: trigger, echo wait and sample accumulation, one item per tick.
// Depends on uer_pkg; output register feeds the mean pipeline.
module uer_fsm #(
   parameter int SAMPLES = uer_pkg::SAMPLES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  uer_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_echo,
   output logic             out_valid,
   input  logic             out_ready,
   output uer_pkg::tick_type out_data
);
   import uer_pkg::*;

   localparam int SI_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam logic [SI_W-1:0] LAST_IDX = SI_W'(SAMPLES - 1);

   localparam logic [1:0] PH_IDLE      = 2'd0;
   localparam logic [1:0] PH_TRIG      = 2'd1;
   localparam logic [1:0] PH_WAIT_HIGH = 2'd2;
   localparam logic [1:0] PH_WAIT_LOW  = 2'd3;

   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] tick_ff, tick_in;
   logic [SI_W-1:0]  idx_ff, idx_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             oval_ff;
   tick_type         odata_ff, odata_in;

   logic             accept;
   logic [CNT_W-1:0] trig_len;
   logic [CNT_W-1:0] trig_cnt;
   logic [CNT_W-1:0] tick_adv;
   logic [SUM_W-1:0] sum_add;

   assign req_ready = !oval_ff || out_ready;
   assign accept    = req_valid && req_ready;
   assign out_valid = oval_ff;
   assign out_data  = odata_ff;

   assign trig_len = (cfg.trig_ticks == '0) ? CNT_W'(1) : cfg.trig_ticks;
   assign trig_cnt = ((phase_ff == PH_IDLE) ? '0 : tick_ff) + CNT_W'(1);
   assign tick_adv = (tick_ff >= cfg.period) ? '0 : tick_ff + CNT_W'(1);
   assign sum_add  = sum_ff + SUM_W'(tick_ff);

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      odata_in = '0;
      if (!cfg.enable) begin
         phase_in = PH_IDLE;
         tick_in  = '0;
         idx_in   = '0;
         sum_in   = '0;
      end else begin
         case (phase_ff)
            PH_IDLE, PH_TRIG: begin
               odata_in.trig = 1'b1;
               if (trig_cnt >= trig_len) begin
                  tick_in  = '0;
                  phase_in = PH_WAIT_HIGH;
               end else begin
                  tick_in  = trig_cnt;
                  phase_in = PH_TRIG;
               end
            end
            PH_WAIT_HIGH: begin
               if (req_echo) begin
                  phase_in = PH_WAIT_LOW;
               end
               tick_in = tick_adv;
            end
            PH_WAIT_LOW: begin
               if (!req_echo) begin
                  tick_in  = '0;
                  phase_in = PH_IDLE;
                  if (idx_ff == LAST_IDX) begin
                     odata_in.valid_res = 1'b1;
                     odata_in.sum       = sum_add;
                     idx_in             = '0;
                     sum_in             = '0;
                  end else begin
                     idx_in = idx_ff + SI_W'(1);
                     sum_in = sum_add;
                  end
               end else begin
                  tick_in = tick_adv;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         idx_ff   <= '0;
         sum_ff   <= '0;
         oval_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            idx_ff   <= idx_in;
            sum_ff   <= sum_in;
         end
         if (req_ready) begin
            oval_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         odata_ff <= odata_in;
      end
   end

endmodule

// ----- rtl/core/uer_mean.sv -----
// Mean pipeline: sum*scale, >>8, divide by sample count, subtract offset, saturate.
// Depends on uer_pkg; four registered stages with per-stage ready.
module uer_mean #(
   parameter int SAMPLES = uer_pkg::SAMPLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  uer_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  uer_pkg::tick_type                 in_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_trig,
   output logic                              rsp_valid_res,
   output logic signed [uer_pkg::DIST_W-1:0] rsp_distance
);
   import uer_pkg::*;

   localparam int RCP_W = P_W + 1;
   localparam int EST_W = P_W + RCP_W;
   localparam int NW    = $clog2(SAMPLES + 1);
   localparam int QN_W  = P_W + NW;
   localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << P_W) / SAMPLES);
   localparam logic [NW-1:0]    DIV   = NW'(SAMPLES);

   // stage 2: product
   logic              v2_ff, t2_ff, r2_ff;
   logic [PROD_W-1:0] prod_ff;
   // stage 3: reciprocal estimate
   logic              v3_ff, t3_ff, r3_ff;
   logic [P_W-1:0]    p3_ff;
   logic [EST_W-1:0]  est_ff;
   // stage 4: corrected quotient
   logic              v4_ff, t4_ff, r4_ff;
   logic [P_W-1:0]    q_ff, q_in;
   // stage 5: output
   logic              v5_ff, t5_ff, r5_ff;
   logic [DIST_W-1:0] dist_ff, dist_in;

   logic              rdy2, rdy3, rdy4, rdy5;
   logic [P_W-1:0]    p_sh;
   logic [P_W-1:0]    q0;
   logic [QN_W-1:0]   rem;
   logic signed [DIFF_W-1:0] diff;

   assign rdy5     = !v5_ff || rsp_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = rdy2;

   assign p_sh = prod_ff[PROD_W-1:8];
   assign q0   = est_ff[P_W +: P_W];
   assign rem  = QN_W'(p3_ff) - QN_W'(q0) * QN_W'(DIV);
   assign q_in = (rem >= QN_W'(DIV)) ? q0 + P_W'(1) : q0;

   assign diff = signed'({2'b00, q_ff}) - signed'(DIFF_W'(cfg.offset));
   always_comb begin
      if (!r4_ff) begin
         dist_in = '0;
      end else if (diff > DIST_MAX) begin
         dist_in = DIST_MAX[DIST_W-1:0];
      end else begin
         dist_in = diff[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy2) v2_ff <= in_valid;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && in_valid) begin
         t2_ff   <= in_data.trig;
         r2_ff   <= in_data.valid_res;
         prod_ff <= PROD_W'(in_data.sum) * PROD_W'(cfg.scale);
      end
      if (rdy3 && v2_ff) begin
         t3_ff  <= t2_ff;
         r3_ff  <= r2_ff;
         p3_ff  <= p_sh;
         est_ff <= EST_W'(p_sh) * EST_W'(RECIP);
      end
      if (rdy4 && v3_ff) begin
         t4_ff <= t3_ff;
         r4_ff <= r3_ff;
         q_ff  <= q_in;
      end
      if (rdy5 && v4_ff) begin
         t5_ff   <= t4_ff;
         r5_ff   <= r4_ff;
         dist_ff <= dist_in;
      end
   end

   assign rsp_valid     = v5_ff;
   assign rsp_trig      = t5_ff;
   assign rsp_valid_res = r5_ff;
   assign rsp_distance  = signed'(dist_ff);

endmodule

// ----- rtl/core/ultrasonic_echo_ranger.sv -----
// Ultrasonic echo ranger top level: configuration registers, sequencer, mean pipeline.
// Depends on uer_pkg, uer_fsm and uer_mean.
//
// Usage:
//  - Each req_ item is one timer tick carrying the sampled echo level (req_echo).
//  - Each tick yields exactly one rsp_ item: trigger level, a fresh-mean flag and
//    the mean distance in Q8 centimeters (zero when rsp_valid_res is low).
//  - An accepted item passes through the sequencer register and four mean stages
//    (multiply, reciprocal multiply, quotient correction, offset and clamp) to
//    rsp_valid; one item per cycle is sustained while rsp_ready is high.
//  - csr_wen writes register csr_index (enable, trig_ticks, period, scale, offset)
//    at once; write only while no item is in flight. Other indexes are ignored.
//  - Reset clears the sequencer, empties the pipeline and loads register defaults
//    (disabled, 30 trigger ticks, period 50000, scale 374, offset 40 cm).
//  - When rsp_ready is low, stages hold; each stage frees its slot once passed on,
//    so req_ready stays high until all five stage registers are full.
module ultrasonic_echo_ranger #(
   parameter int SAMPLES = uer_pkg::SAMPLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [uer_pkg::IDX_W-1:0]         csr_index,
   input  logic [uer_pkg::CSR_W-1:0]         csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_echo,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_trig,
   output logic                              rsp_valid_res,
   output logic signed [uer_pkg::DIST_W-1:0] rsp_distance
);
   import uer_pkg::*;

   cfg_type  cfg_ff;
   logic     fsm_valid;
   logic     mean_ready;
   tick_type fsm_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable     <= 1'b0;
         cfg_ff.trig_ticks <= TRIG_TICKS_RST;
         cfg_ff.period     <= PERIOD_RST;
         cfg_ff.scale      <= SCALE_RST;
         cfg_ff.offset     <= OFFSET_RST;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_ENABLE:     cfg_ff.enable     <= csr_wdata[0];
            CSR_TRIG_TICKS: cfg_ff.trig_ticks <= csr_wdata;
            CSR_PERIOD:     cfg_ff.period     <= csr_wdata;
            CSR_SCALE:      cfg_ff.scale      <= csr_wdata[SCALE_W-1:0];
            CSR_OFFSET:     cfg_ff.offset     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   uer_fsm #(
      .SAMPLES (SAMPLES)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_echo  (req_echo),
      .out_valid (fsm_valid),
      .out_ready (mean_ready),
      .out_data  (fsm_data)
   );

   uer_mean #(
      .SAMPLES (SAMPLES)
   ) u_mean (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (fsm_valid),
      .in_ready      (mean_ready),
      .in_data       (fsm_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_trig      (rsp_trig),
      .rsp_valid_res (rsp_valid_res),
      .rsp_distance  (rsp_distance)
   );

endmodule
